// ===== sv/ksc_pkg.sv =====
package ksc_pkg;

	// Alphabet
	localparam int NumLetters = 26;
	localparam int LetterW    = 5;
	localparam logic [7:0] ChLowerA = 8'h61;
	localparam logic [7:0] ChLowerZ = 8'h7a;
	localparam logic [7:0] ChUpperA = 8'h41;
	localparam logic [7:0] ChUpperZ = 8'h5a;
	localparam logic [NumLetters-1:0] AllLetters = '1;

	// Command queue between front and back
	localparam int QueueDepth = 4;
	localparam int QueuePtrW  = $clog2(QueueDepth);
	localparam int QueueCntW  = $clog2(QueueDepth + 1);

	// Result buffer
	localparam int OutDepth = 2;
	localparam int OutPtrW  = $clog2(OutDepth);
	localparam int OutCntW  = $clog2(OutDepth + 1);

	typedef enum logic [1:0] {
		OP_CLEAR   = 2'd0,
		OP_KEY     = 2'd1,
		OP_FINISH  = 2'd2,
		OP_ENCRYPT = 2'd3
	} opcode_t;

	// Classified command
	typedef struct packed {
		opcode_t            op;
		logic               is_letter;
		logic               upper;
		logic [LetterW-1:0] idx;
		logic [7:0]         ch;
	} cmd_t;

endpackage

// ===== sv/keyword_substitution_cipher.sv =====
// Channel   Ports                          Beat taken when
// input     opcode, in_char   push, full   push && !full
// result    out_char, key_ready empty, pop pop && !empty
//
// Encrypt, clear and keyword beats stream through the back end at one beat a
// cycle while the result buffer has room for encrypts; a beat goes through
// the command queue, then the back end puts its result in the result buffer.
// Finish key holds the back end for the beat itself, then the alphabet walk,
// one letter a cycle. Reset loads the identity alphabet and marks the key
// ready. A four-entry command queue and two-entry result buffer absorb stalls.
module keyword_substitution_cipher (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] opcode,
	input  logic [7:0] in_char,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_char,
	output logic       key_ready
);

	ksc_pkg::cmd_t wr_cmd;
	ksc_pkg::cmd_t rd_cmd;
	logic          wr_en;
	logic          rd_en;
	logic          q_empty;

	// Front: accept and classify
	ksc_front u_front (
		.push       (push),
		.queue_full (full),
		.opcode     (opcode),
		.in_char    (in_char),
		.wr_en      (wr_en),
		.cmd        (wr_cmd)
	);

	// Command queue
	ksc_cmd_fifo u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_cmd),
		.rd_en   (rd_en),
		.rd_data (rd_cmd),
		.full    (full),
		.empty   (q_empty)
	);

	// Back: key build and encryption
	ksc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (rd_cmd),
		.cmd_empty (q_empty),
		.cmd_pop   (rd_en),
		.pop       (pop),
		.empty     (empty),
		.out_char  (out_char),
		.key_ready (key_ready)
	);

endmodule

// ===== sv/ksc_front.sv =====
module ksc_front (
	input  logic            push,
	input  logic            queue_full,
	input  logic [1:0]      opcode,
	input  logic [7:0]      in_char,
	output logic            wr_en,
	output ksc_pkg::cmd_t   cmd
);

	logic is_lower;
	logic is_upper;
	logic [7:0] offs;

	// Accept a beat whenever the queue has room
	assign wr_en = push && !queue_full;

	// Letter classification and alphabet index
	assign is_lower = (in_char >= ksc_pkg::ChLowerA) && (in_char <= ksc_pkg::ChLowerZ);
	assign is_upper = (in_char >= ksc_pkg::ChUpperA) && (in_char <= ksc_pkg::ChUpperZ);
	assign offs     = is_lower ? (in_char - ksc_pkg::ChLowerA) : (in_char - ksc_pkg::ChUpperA);

	always_comb begin
		cmd.op        = ksc_pkg::opcode_t'(opcode);
		cmd.is_letter = is_lower || is_upper;
		cmd.upper     = is_upper;
		cmd.idx       = offs[ksc_pkg::LetterW-1:0];
		cmd.ch        = in_char;
	end

endmodule

// ===== sv/ksc_cmd_fifo.sv =====
module ksc_cmd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  ksc_pkg::cmd_t   wr_data,
	input  logic            rd_en,
	output ksc_pkg::cmd_t   rd_data,
	output logic            full,
	output logic            empty
);

	ksc_pkg::cmd_t mem_q [ksc_pkg::QueueDepth];
	logic [ksc_pkg::QueuePtrW-1:0] wptr_q;
	logic [ksc_pkg::QueuePtrW-1:0] rptr_q;
	logic [ksc_pkg::QueueCntW-1:0] cnt_q;

	assign full    = (cnt_q == ksc_pkg::QueueCntW'(ksc_pkg::QueueDepth));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr_en)
				wptr_q <= wptr_q + 1'b1;
			if (rd_en)
				rptr_q <= rptr_q + 1'b1;
			if (wr_en && !rd_en)
				cnt_q <= cnt_q + 1'b1;
			else if (rd_en && !wr_en)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wptr_q] <= wr_data;
	end

endmodule

// ===== sv/ksc_back.sv =====
module ksc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  ksc_pkg::cmd_t   cmd,
	input  logic            cmd_empty,
	output logic            cmd_pop,
	input  logic            pop,
	output logic            empty,
	output logic [7:0]      out_char,
	output logic            key_ready
);

	typedef enum logic {
		ST_RUN,
		ST_FILL
	} state_t;

	state_t state_q;
	logic [ksc_pkg::LetterW-1:0]    table_q [ksc_pkg::NumLetters];
	logic [ksc_pkg::NumLetters-1:0] used_q;
	logic [ksc_pkg::LetterW-1:0]    klen_q;
	logic                           valid_q;
	logic [ksc_pkg::LetterW-1:0]    walk_q;

	logic [7:0] obuf_char_q [ksc_pkg::OutDepth];
	logic       obuf_rdy_q  [ksc_pkg::OutDepth];
	logic [ksc_pkg::OutPtrW-1:0] owptr_q;
	logic [ksc_pkg::OutPtrW-1:0] orptr_q;
	logic [ksc_pkg::OutCntW-1:0] ocnt_q;

	logic                        out_space;
	logic                        obuf_push;
	logic                        obuf_pop;
	logic                        room;
	logic [ksc_pkg::LetterW-1:0] sub;
	logic [7:0]                  enc_char;

	assign out_space = (ocnt_q != ksc_pkg::OutCntW'(ksc_pkg::OutDepth));
	assign room      = (klen_q < ksc_pkg::LetterW'(ksc_pkg::NumLetters));

	// Take a command when idle and, for encrypt, when the result buffer has room
	assign cmd_pop   = (state_q == ST_RUN) && !cmd_empty &&
		((cmd.op != ksc_pkg::OP_ENCRYPT) || out_space);
	assign obuf_push = cmd_pop && (cmd.op == ksc_pkg::OP_ENCRYPT);

	// Substitution, case kept
	assign sub = table_q[cmd.idx];
	always_comb begin
		enc_char = cmd.ch;
		if (valid_q && cmd.is_letter)
			enc_char = (cmd.upper ? ksc_pkg::ChUpperA : ksc_pkg::ChLowerA) + {3'b000, sub};
	end

	// Key state and finish walk, one letter a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			used_q  <= '0;
			klen_q  <= '0;
			valid_q <= 1'b1;
			walk_q  <= '0;
			for (int i = 0; i < ksc_pkg::NumLetters; i++)
				table_q[i] <= ksc_pkg::LetterW'(i);
		end else begin
			case (state_q)
				ST_RUN: begin
					if (cmd_pop) begin
						case (cmd.op)
							ksc_pkg::OP_CLEAR: begin
								used_q  <= '0;
								klen_q  <= '0;
								valid_q <= 1'b0;
							end
							ksc_pkg::OP_KEY: begin
								valid_q <= 1'b0;
								if (cmd.is_letter && !used_q[cmd.idx] && room) begin
									table_q[klen_q]  <= cmd.idx;
									klen_q           <= klen_q + 1'b1;
									used_q[cmd.idx]  <= 1'b1;
								end
							end
							ksc_pkg::OP_FINISH: begin
								walk_q  <= '0;
								state_q <= ST_FILL;
							end
							default: begin
							end
						endcase
					end
				end
				ST_FILL: begin
					if (!used_q[walk_q] && room)
						table_q[klen_q] <= walk_q;
					if (walk_q == ksc_pkg::LetterW'(ksc_pkg::NumLetters - 1)) begin
						used_q  <= ksc_pkg::AllLetters;
						klen_q  <= ksc_pkg::LetterW'(ksc_pkg::NumLetters);
						valid_q <= 1'b1;
						state_q <= ST_RUN;
					end else begin
						if (!used_q[walk_q] && room)
							klen_q <= klen_q + 1'b1;
						used_q[walk_q] <= 1'b1;
						walk_q         <= walk_q + 1'b1;
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	// Result buffer
	assign empty     = (ocnt_q == '0);
	assign obuf_pop  = pop && !empty;
	assign out_char  = obuf_char_q[orptr_q];
	assign key_ready = obuf_rdy_q[orptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owptr_q <= '0;
			orptr_q <= '0;
			ocnt_q  <= '0;
		end else begin
			if (obuf_push)
				owptr_q <= owptr_q + 1'b1;
			if (obuf_pop)
				orptr_q <= orptr_q + 1'b1;
			if (obuf_push && !obuf_pop)
				ocnt_q <= ocnt_q + 1'b1;
			else if (obuf_pop && !obuf_push)
				ocnt_q <= ocnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (obuf_push) begin
			obuf_char_q[owptr_q] <= enc_char;
			obuf_rdy_q[owptr_q]  <= valid_q;
		end
	end

endmodule

// ===== sv/ksc_checker.sv =====
module ksc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic [7:0] out_char,
	input logic       key_ready
);

	// A waiting result holds while it is not taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_char) && $stable(key_ready))
		else $error("result changed while stalled");

	// The queue fills only through an accepted beat
	a_full_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full rose without a push");

	// Results drain only through a pop
	a_empty_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(empty) |-> $past(pop))
		else $error("result lost without a pop");

	// Nothing queued straight after reset
	a_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !full && empty)
		else $error("queues not clear after reset");

endmodule

bind keyword_substitution_cipher ksc_checker u_chk (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;

	localparam int RandItems = 620;
	localparam int DrainCycles = 40;   // finish walks 26 letters, plus the pipe

	logic       clk = 1'b0;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [1:0] opcode;
	logic [7:0] in_char;
	logic       empty;
	logic       pop;
	logic [7:0] out_char;
	logic       key_ready;

	keyword_substitution_cipher u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.opcode    (opcode),
		.in_char   (in_char),
		.empty     (empty),
		.pop       (pop),
		.out_char  (out_char),
		.key_ready (key_ready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#2ms;
		$display("tb: done, errors");
		$finish;
	end

	// Cipher state as seen from outside
	logic [ksc_pkg::LetterW-1:0]    alpha_tab [ksc_pkg::NumLetters];
	logic [ksc_pkg::NumLetters-1:0] letter_used;
	int                             alpha_len;
	logic                           alpha_ready;

	typedef struct {
		logic [7:0] ch;
		logic       rdy;
	} cipher_out_t;

	cipher_out_t cipher_out_q [$];
	int          n_err = 0;
	int          sent = 0;

	function automatic void alpha_append(int idx);
		if (alpha_len >= ksc_pkg::NumLetters || letter_used[idx])
			return;
		alpha_tab[alpha_len] = idx[ksc_pkg::LetterW-1:0];
		alpha_len++;
		letter_used[idx] = 1'b1;
	endfunction

	function automatic void alpha_reset();
		for (int i = 0; i < ksc_pkg::NumLetters; i++)
			alpha_tab[i] = i[ksc_pkg::LetterW-1:0];
		letter_used = '0;
		alpha_len   = 0;
		alpha_ready = 1'b1;
	endfunction

	// Advance the cipher by one command; encrypt yields a ciphertext beat
	function automatic bit cipher_step(input ksc_pkg::opcode_t op, input logic [7:0] ch,
			output cipher_out_t res);
		res.ch  = ch;
		res.rdy = alpha_ready;
		case (op)
			ksc_pkg::OP_CLEAR: begin
				letter_used = '0;
				alpha_len   = 0;
				alpha_ready = 1'b0;
				return 0;
			end
			ksc_pkg::OP_KEY: begin
				alpha_ready = 1'b0;
				if (ch >= ksc_pkg::ChLowerA && ch <= ksc_pkg::ChLowerZ)
					alpha_append(int'(ch - ksc_pkg::ChLowerA));
				else if (ch >= ksc_pkg::ChUpperA && ch <= ksc_pkg::ChUpperZ)
					alpha_append(int'(ch - ksc_pkg::ChUpperA));
				return 0;
			end
			ksc_pkg::OP_FINISH: begin
				for (int i = 0; i < ksc_pkg::NumLetters; i++)
					alpha_append(i);
				letter_used = ksc_pkg::AllLetters;
				alpha_len   = ksc_pkg::NumLetters;
				alpha_ready = 1'b1;
				return 0;
			end
			default: begin
				if (alpha_ready) begin
					if (ch >= ksc_pkg::ChLowerA && ch <= ksc_pkg::ChLowerZ)
						res.ch = ksc_pkg::ChLowerA +
							8'(alpha_tab[ch - ksc_pkg::ChLowerA]);
					else if (ch >= ksc_pkg::ChUpperA && ch <= ksc_pkg::ChUpperZ)
						res.ch = ksc_pkg::ChUpperA +
							8'(alpha_tab[ch - ksc_pkg::ChUpperA]);
				end
				return 1;
			end
		endcase
	endfunction

	function automatic logic [7:0] rand_letter();
		logic [7:0] base;
		base = $urandom_range(0, 1) ? ksc_pkg::ChUpperA : ksc_pkg::ChLowerA;
		return base + 8'($urandom_range(0, ksc_pkg::NumLetters - 1));
	endfunction

	// Directed beats; known = 1 carries a hand-read result
	typedef struct {
		ksc_pkg::opcode_t op;
		logic [7:0]       ch;
		bit               known;
		logic [7:0]       k_ch;
		logic             k_rdy;
	} plan_row_t;

	localparam int PlanLen = 26;
	plan_row_t plan [PlanLen] = '{
		'{ksc_pkg::OP_ENCRYPT, "a",   1, "a",   1'b1},  // identity alphabet after reset
		'{ksc_pkg::OP_ENCRYPT, "Z",   1, "Z",   1'b1},
		'{ksc_pkg::OP_ENCRYPT, 8'h00, 1, 8'h00, 1'b1},
		'{ksc_pkg::OP_ENCRYPT, 8'hff, 1, 8'hff, 1'b1},
		'{ksc_pkg::OP_KEY,     "K",   0, 8'h00, 1'b0},  // keyword with no clear first
		'{ksc_pkg::OP_ENCRYPT, "b",   1, "b",   1'b0},  // key not ready: passed through
		'{ksc_pkg::OP_FINISH,  8'hff, 0, 8'h00, 1'b0},
		'{ksc_pkg::OP_ENCRYPT, "a",   0, 8'h00, 1'b0},
		'{ksc_pkg::OP_ENCRYPT, "Z",   0, 8'h00, 1'b0},
		'{ksc_pkg::OP_FINISH,  8'h00, 0, 8'h00, 1'b0},  // second finish
		'{ksc_pkg::OP_KEY,     "q",   0, 8'h00, 1'b0},  // ignored after finish
		'{ksc_pkg::OP_ENCRYPT, "q",   1, "q",   1'b0},
		'{ksc_pkg::OP_FINISH,  8'h00, 0, 8'h00, 1'b0},  // same table back
		'{ksc_pkg::OP_ENCRYPT, "q",   0, 8'h00, 1'b0},
		'{ksc_pkg::OP_CLEAR,   8'h5a, 0, 8'h00, 1'b0},
		'{ksc_pkg::OP_KEY,     "Z",   0, 8'h00, 1'b0},
		'{ksc_pkg::OP_KEY,     "e",   0, 8'h00, 1'b0},
		'{ksc_pkg::OP_KEY,     "B",   0, 8'h00, 1'b0},
		'{ksc_pkg::OP_KEY,     "!",   0, 8'h00, 1'b0},  // not a letter
		'{ksc_pkg::OP_KEY,     "z",   0, 8'h00, 1'b0},  // repeat letter
		'{ksc_pkg::OP_KEY,     8'hc1, 0, 8'h00, 1'b0},  // high byte
		'{ksc_pkg::OP_FINISH,  8'h00, 0, 8'h00, 1'b0},
		'{ksc_pkg::OP_ENCRYPT, "y",   0, 8'h00, 1'b0},
		'{ksc_pkg::OP_ENCRYPT, 8'h80, 1, 8'h80, 1'b1},
		'{ksc_pkg::OP_ENCRYPT, "@",   1, "@",   1'b1},
		'{ksc_pkg::OP_ENCRYPT, 8'h7b, 1, 8'h7b, 1'b1}
	};

	// Offer one input beat, idling at random first; push stays high afterwards
	task automatic send_beat(input ksc_pkg::opcode_t op, input logic [7:0] ch,
			input bit known, input logic [7:0] k_ch, input logic k_rdy);
		cipher_out_t res;
		bit          calm;
		calm = (sent >= 100 && sent < 220);
		while (!calm && $urandom_range(0, 99) < 21) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push    <= 1'b1;
		opcode  <= op;
		in_char <= ch;
		do
			@(posedge clk);
		while (full);
		if (cipher_step(op, ch, res)) begin
			if (known) begin
				res.ch  = k_ch;
				res.rdy = k_rdy;
			end
			cipher_out_q.push_back(res);
		end
		sent++;
	endtask

	// Sender
	initial begin
		int  pick;
		int  n;
		bit  paused;
		paused  = 0;
		push    <= 1'b0;
		opcode  <= ksc_pkg::OP_CLEAR;
		in_char <= 8'h00;
		arst_n  <= 1'b0;
		alpha_reset();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send_beat(plan[i].op, plan[i].ch, plan[i].known, plan[i].k_ch, plan[i].k_rdy);

		while (sent < PlanLen + RandItems) begin
			// once: let the block drain completely
			if (!paused && sent >= 400) begin
				paused = 1;
				push <= 1'b0;
				while (cipher_out_q.size() != 0)
					@(posedge clk);
			end
			pick = $urandom_range(0, 99);
			if (pick < 78) begin
				// clear (mostly), keyword, finish (mostly), then a run of plaintext
				if ($urandom_range(0, 9) != 0)
					send_beat(ksc_pkg::OP_CLEAR, 8'($urandom), 0, 8'h00, 1'b0);
				n = $urandom_range(0, 12);
				repeat (n)
					send_beat(ksc_pkg::OP_KEY, ($urandom_range(0, 6) == 0) ? 8'($urandom) :
						rand_letter(), 0, 8'h00, 1'b0);
				if ($urandom_range(0, 9) != 0)
					send_beat(ksc_pkg::OP_FINISH, 8'($urandom), 0, 8'h00, 1'b0);
				n = $urandom_range(3, 20);
				repeat (n)
					send_beat(ksc_pkg::OP_ENCRYPT,
						($urandom_range(0, 3) == 0) ? 8'($urandom) : rand_letter(),
						0, 8'h00, 1'b0);
			end else begin
				// noise
				n = $urandom_range(1, 8);
				repeat (n)
					send_beat(ksc_pkg::opcode_t'($urandom_range(0, 3)), 8'($urandom),
						0, 8'h00, 1'b0);
			end
		end

		push <= 1'b0;
		while (cipher_out_q.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (cipher_out_q.size() != 0) begin
			$error("%0d ciphertext beats never arrived", cipher_out_q.size());
			n_err++;
		end
		if (n_err == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	// Receiver: check each popped beat, one long hold-off to back the block up
	initial begin
		cipher_out_t e;
		int          popped;
		int          hold_left;
		popped    = 0;
		hold_left = 0;
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				if (cipher_out_q.size() == 0) begin
					$error("ciphertext beat with nothing expected: out_char %h", out_char);
					n_err++;
				end else begin
					e = cipher_out_q.pop_front();
					if (out_char !== e.ch) begin
						$error("out_char: expected %h, got %h", e.ch, out_char);
						n_err++;
					end
					if (key_ready !== e.rdy) begin
						$error("key_ready: expected %b, got %b", e.rdy, key_ready);
						n_err++;
					end
				end
				popped++;
				if (popped == 40)
					hold_left = 60;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (popped >= 200 && popped < 300) begin
				pop <= 1'b1;
			end else begin
				pop <= ($urandom_range(0, 99) >= 21);
			end
		end
	end

endmodule
